FILE: design/dwms_pkg.sv
`timescale 1ns / 1ps

package dwms_pkg;

  localparam int unsigned CmdWidth    = 3;
  localparam int unsigned ValueWidth  = 16;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CONTAINS   = 3'd4
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    logic [CmdWidth-1:0]   cmd;
    logic [ValueWidth-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [ValueWidth-1:0]  popped_value;
    logic                   found;
    logic [CountWidth-1:0]  entry_count;
    logic                   is_empty;
    logic [StatusWidth-1:0] status;
  } res_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic push_back;
  } cell_ctrl_t;

endpackage

FILE: design/dwms_cell.sv
`timescale 1ns / 1ps

module dwms_cell
  import dwms_pkg::*;
#(
  parameter int unsigned Idx = 0,
  parameter int unsigned CW  = 7,
  parameter int unsigned VW  = 16
) (
  input  logic          clk_i,
  input  cell_ctrl_t    ctrl_i,
  input  logic [CW-1:0] count_i,
  input  logic [VW-1:0] key_i,
  input  logic [VW-1:0] left_i,
  input  logic [VW-1:0] right_i,
  output logic [VW-1:0] data_o,
  output logic          match_o,
  output logic [VW-1:0] tap_o
);

  logic [VW-1:0] data_q, data_d;
  logic          held;
  logic          is_last;
  logic          is_next;

  assign held    = count_i > CW'(Idx);
  assign is_last = count_i == CW'(Idx + 1);
  assign is_next = count_i == CW'(Idx);

  always_comb begin
    priority if (ctrl_i.shift_right) begin
      data_d = left_i;
    end else if (ctrl_i.shift_left) begin
      data_d = right_i;
    end else if (ctrl_i.push_back && is_next) begin
      data_d = key_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = held && (data_q == key_i);
  assign tap_o   = is_last ? data_q : '0;

endmodule

FILE: design/deque_with_membership_search.sv
`timescale 1ns / 1ps

// Double-ended queue of DEPTH identifiers held in a row of cells, front in
// cell 0. One word is taken every cycle (busy_o stays low); its result is on
// res_o, flagged by valid_o for one cycle, on the cycle after start_i. Pushes
// and pops at the front shift the whole row by one cell, back operations
// touch the cell at the fill mark, and a membership query compares every
// held cell at once. The receiver cannot stall, so each result must be
// taken in the cycle it is shown.
module deque_with_membership_search
  import dwms_pkg::*;
#(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic valid_o,
  output res_t res_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = VALUE_WIDTH;

  logic [CW-1:0] count_q, count_d;
  logic          valid_q;
  res_t          res_q, res_d;

  logic [VW-1:0] key;
  logic [VW-1:0] cell_data [DEPTH];
  logic [VW-1:0] cell_tap  [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [VW-1:0] back_value;
  cell_ctrl_t    ctrl;
  logic          full, empty, take;
  logic [VW-1:0] popped;
  logic          found;
  status_e       status;
  logic [CountWidth-1:0] count_out;
  logic [ValueWidth-1:0] popped_out;

  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;
  assign full   = count_q == CW'(DEPTH);
  assign empty  = count_q == '0;

  if (VW >= ValueWidth) begin : g_key_wide
    assign key        = VW'(req_i.item_value);
    assign popped_out = popped[ValueWidth-1:0];
  end else begin : g_key_narrow
    assign key        = req_i.item_value[VW-1:0];
    assign popped_out = {{(ValueWidth - VW){1'b0}}, popped};
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = key;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    dwms_cell #(
      .Idx(i),
      .CW (CW),
      .VW (VW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .count_i(count_q),
      .key_i  (key),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i]),
      .match_o(cell_match[i]),
      .tap_o  (cell_tap[i])
    );
  end

  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | cell_tap[i];
    end
  end

  always_comb begin
    ctrl    = '0;
    count_d = count_q;
    popped  = '0;
    found   = 1'b0;
    status  = ST_OK;
    if (take) begin
      unique case (req_i.cmd)
        CMD_PUSH_BACK: begin
          if (full) begin
            status = ST_OVERFLOW;
          end else begin
            ctrl.push_back = 1'b1;
            count_d        = count_q + CW'(1);
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) begin
            status = ST_OVERFLOW;
          end else begin
            ctrl.shift_right = 1'b1;
            count_d          = count_q + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status = ST_UNDERFLOW;
          end else begin
            ctrl.shift_left = 1'b1;
            popped          = cell_data[0];
            count_d         = count_q - CW'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            status = ST_UNDERFLOW;
          end else begin
            popped  = back_value;
            count_d = count_q - CW'(1);
          end
        end
        CMD_CONTAINS: begin
          found = |cell_match;
        end
        default: begin
        end
      endcase
    end
  end

  if (CW >= CountWidth) begin : g_cnt_wide
    assign count_out = count_d[CountWidth-1:0];
  end else begin : g_cnt_narrow
    assign count_out = {{(CountWidth - CW){1'b0}}, count_d};
  end

  always_comb begin
    res_d.popped_value = popped_out;
    res_d.found        = found;
    res_d.entry_count  = count_out;
    res_d.is_empty     = count_d == '0;
    res_d.status       = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
